// ===== rtl/pbmu_pkg.sv =====
`default_nettype none
package pbmu_pkg;

	localparam int PhaseGain = 83443;
	localparam logic signed [16:0] PiQ13 = 17'sd25736;
	localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
	// makes any heading sum positive and centers the wrap window on zero
	localparam logic signed [22:0] WrapBias = 23'sd1672839;
	// floor(2^30 / 3217), 3217 being 51472 / 16
	localparam logic [18:0] WrapRecip = 19'd333771;

	localparam logic [0:0] REG_TIME_STEP = 1'b0;
	localparam logic [0:0] REG_STEP_WB = 1'b1;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [15:0] speed;
		logic signed [15:0] steer;
		logic last_in;
	} pbmu_in_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [15:0] new_heading;
		logic last_out;
	} pbmu_out_t;

	// angle (Q3.13, up to 17 bits signed) to 16 bit phase of a full turn
	function automatic logic [15:0] to_phase(input logic signed [16:0] a);
		logic signed [35:0] m;
		m = 36'(a) * 36'(PhaseGain) + 36'sd32768;
		return m[31:16];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pbmu_sine.sv =====
`default_nettype none
// Five-stage polynomial sine of a 16 bit phase, Q1.14 result.
module pbmu_sine (
	input  wire logic              clk,
	input  wire logic [15:0]       phase,
	output logic signed [15:0]     sine
);

	logic [14:0] t_c;
	logic [14:0] t_s1, t_s2, t_s3, t_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [14:0] t2_s2, t2_s3;
	logic [13:0] c_s3;
	logic [15:0] d_s4;
	logic [29:0] m1, m2, m3, m4;
	logic [15:0] d_c;
	logic [15:0] lim;

	always_comb begin
		// fold the odd quadrants onto the rising quarter wave
		t_c = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		m1 = 30'(t_s1) * 30'(t_s1);
		m2 = 30'(t2_s2) * 30'd1160;
		m3 = 30'(14'd10512 - c_s3) * 30'(t2_s3);
		d_c = 16'd25736 - 16'(m3 >> 14);
		m4 = 30'(d_s4) * 30'(t_s4);
		lim = (m4 > 30'd268435456) ? 16'd16384 : 16'(m4 >> 14);
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_c;
		neg_s1 <= phase[15];
		t_s2 <= t_s1;
		neg_s2 <= neg_s1;
		t2_s2 <= 15'(m1 >> 14);
		t_s3 <= t_s2;
		neg_s3 <= neg_s2;
		t2_s3 <= t2_s2;
		c_s3 <= 14'(m2 >> 14);
		t_s4 <= t_s3;
		neg_s4 <= neg_s3;
		d_s4 <= d_c;
		sine <= neg_s4 ? -$signed(lim) : $signed(lim);
	end

endmodule
`default_nettype wire

// ===== rtl/particle_bicycle_motion_update.sv =====
`default_nettype none
// Bicycle-model particle predictor. One particle enters per cycle when start
// is high; its result appears with done high and must be taken then: there
// is no output stall. busy is always low. Each particle passes through the
// five-stage sine unit, then the product, sum, saturation/wrap-quotient and
// output stages.
module particle_bicycle_motion_update
	import pbmu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire pbmu_in_t  item_in,
	output logic           done,
	output pbmu_out_t      item_out,
	input  wire logic      cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int Lat = 5;

	logic [15:0] dt_q, wb_q;
	logic [15:0] ph_hs, ph_hc, ph_st;
	logic signed [15:0] s_hs, s_hc, s_st;
	pbmu_in_t d_s [Lat+1];
	logic [Lat+3:0] v_q;
	logic signed [31:0] vdt_s1;
	logic signed [31:0] vw_s1;
	logic signed [31:0] vdt_d [Lat-1];
	logic signed [31:0] vw_d [Lat-1];
	logic signed [47:0] px_s6, py_s6, ph_s6;
	logic signed [32:0] dx, dy;
	logic signed [21:0] dh;
	logic signed [33:0] sx, sy;
	logic signed [22:0] sh;
	logic signed [15:0] hw;
	logic last_s7;
	logic signed [33:0] sx_s7, sy_s7;
	logic signed [22:0] sh_s7;
	logic [21:0] wu;
	logic [36:0] wq;
	logic [21:0] wr;
	logic signed [31:0] nx_s8, ny_s8;
	logic [21:0] wu_s8;
	logic [5:0] wq_s8;
	logic keep_s8;
	logic signed [15:0] sh_s8;
	logic last_s8;

	assign busy = 1'b0;
	assign ph_hs = to_phase(17'(item_in.heading) + 17'(item_in.steer));
	assign ph_hc = ph_hs + 16'd16384;
	assign ph_st = to_phase(17'(item_in.steer));

	pbmu_sine u_s (.clk(clk), .phase(ph_hs), .sine(s_hs));
	pbmu_sine u_c (.clk(clk), .phase(ph_hc), .sine(s_hc));
	pbmu_sine u_g (.clk(clk), .phase(ph_st), .sine(s_st));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 16'd1638;
			wb_q <= 16'd410;
			v_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIME_STEP: dt_q <= cfg_data;
					REG_STEP_WB:   wb_q <= cfg_data;
					default: ;
				endcase
			end
			v_q <= {v_q[Lat+2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		d_s[0] <= item_in;
		vdt_s1 <= 32'(item_in.speed) * $signed({16'd0, dt_q});
		vw_s1 <= 32'(item_in.speed) * $signed({16'd0, wb_q});
		vdt_d[0] <= vdt_s1;
		vw_d[0] <= vw_s1;
		for (int i = 1; i < Lat - 1; i++) begin
			vdt_d[i] <= vdt_d[i-1];
			vw_d[i] <= vw_d[i-1];
		end
		for (int i = 1; i <= Lat; i++) d_s[i] <= d_s[i-1];
		px_s6 <= 48'(vdt_d[Lat-2]) * 48'(s_hc);
		py_s6 <= 48'(vdt_d[Lat-2]) * 48'(s_hs);
		ph_s6 <= 48'(vw_d[Lat-2]) * 48'(s_st);
		last_s7 <= d_s[Lat].last_in;
		sx_s7 <= sx;
		sy_s7 <= sy;
		sh_s7 <= sh;
		nx_s8 <= (sx_s7 > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
			(sx_s7 < -34'sh80000000) ? 32'sh80000000 : 32'(sx_s7);
		ny_s8 <= (sy_s7 > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
			(sy_s7 < -34'sh80000000) ? 32'sh80000000 : 32'(sy_s7);
		wu_s8 <= wu;
		wq_s8 <= 6'(wq >> 30);
		keep_s8 <= (sh_s7 >= -23'(PiQ13)) && (sh_s7 <= 23'(PiQ13));
		sh_s8 <= 16'(sh_s7);
		last_s8 <= last_s7;
	end

	always_comb begin
		dx = 33'((px_s6 + 48'sd2097152) >>> 22);
		dy = 33'((py_s6 + 48'sd2097152) >>> 22);
		dh = 22'((ph_s6 + 48'sd16777216) >>> 25);
		sx = 34'(d_s[Lat].pos_x) + 34'(dx);
		sy = 34'(d_s[Lat].pos_y) + 34'(dy);
		sh = 23'(d_s[Lat].heading) + 23'(dh);
		// quotient by 51472 through a reciprocal; it may come out one low
		wu = 22'(sh_s7 + WrapBias);
		wq = 37'(wu[21:4]) * 37'(WrapRecip);
		wr = wu_s8 - 22'(wq_s8) * 22'(TwoPiQ13);
		if (wr >= 22'(TwoPiQ13))
			wr = wr - 22'(TwoPiQ13);
		hw = 16'(wr) - 16'(PiQ13) + 16'd1;
	end

	always_ff @(posedge clk) begin
		item_out.new_x <= nx_s8;
		item_out.new_y <= ny_s8;
		item_out.new_heading <= keep_s8 ? sh_s8 : hw;
		item_out.last_out <= last_s8;
	end

	assign done = v_q[Lat+3];

endmodule
`default_nettype wire
